>>> sv/vnf_pkg.sv
// vnf_pkg: shared types and constants for the fractal value noise sampler
// no dependencies

package vnf_pkg;
    localparam int TableSize   = 64;
    localparam int MaxOctaves  = 8;
    localparam int CellW       = $clog2(TableSize);
    localparam int LayerW      = $clog2(MaxOctaves);
    localparam int EntryW      = 2 * CellW;
    localparam int AddrW       = LayerW + EntryW;
    localparam int LatDepth    = MaxOctaves * TableSize * TableSize;

    localparam logic [1:0] RegOctaves = 2'd0;
    localparam logic [1:0] RegLacun   = 2'd1;
    localparam logic [1:0] RegGain    = 2'd2;

    localparam logic       OpLoad   = 1'b0;
    localparam logic       OpSample = 1'b1;

    localparam logic [23:0] Q824Max = 24'hFFFFFF;

    typedef struct packed {
        logic        op;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [2:0]  layer_index;
        logic [11:0] entry_index;
        logic [15:0] entry_value;
    } t_item;

    // 24 x 24 product, frac 16 bits removed, saturated to Q8.16
    function automatic logic [23:0] q824_mul_sat(input logic [23:0] a, input logic [23:0] b);
        logic [47:0] p;
        p = 48'(a) * 48'(b);
        q824_mul_sat = (p[47:40] != 8'd0) ? Q824Max : p[39:16];
    endfunction
endpackage

>>> sv/vnf_queue.sv
// vnf_queue: short item queue between the front and the back
// depends on vnf_pkg

module vnf_queue
    import vnf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);
    t_item       r_mem [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 2'd1;
            if (i_pop && !o_empty) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push && !o_full) - 3'(i_pop && !o_empty);
        end
    end
endmodule

>>> sv/vnf_div.sv
// vnf_div: restoring divider, one quotient bit per cycle, saturated to 16 bits
// depends on vnf_pkg

module vnf_div
    import vnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [27:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    // quotient fits 17 bits plus a flag when the high part already exceeds
    logic [63:0] r_num;
    logic [44:0] r_rem;
    logic [16:0] r_q;
    logic [27:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_ovf;
    logic [44:0] w_try;

    assign w_try = {r_rem[43:0], r_num[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                if (w_try >= 45'(r_den)) begin
                    r_rem <= w_try - 45'(r_den);
                    if (r_q[16]) r_ovf <= 1'b1;
                    r_q <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= w_try;
                    if (r_q[16]) r_ovf <= 1'b1;
                    r_q <= {r_q[15:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = (r_ovf || r_q[16]) ? 16'hFFFF : r_q[15:0];
endmodule

>>> sv/vnf_back.sv
// vnf_back: octave sequencer, lattice memory, blend arithmetic and normalizing divide
// depends on vnf_pkg and vnf_div

module vnf_back
    import vnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [3:0]  i_octaves,
    input  logic [23:0] i_lacun,
    input  logic [23:0] i_gain,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_value
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MULX = 10'b0000000010,
        S_SPLT = 10'b0000000100,
        S_SQ   = 10'b0000001000,
        S_SM   = 10'b0000010000,
        S_RD   = 10'b0000100000,
        S_ROW  = 10'b0001000000,
        S_COL  = 10'b0010000000,
        S_ACC  = 10'b0100000000,
        S_DIV  = 10'b1000000000
    } t_state;

    t_state r_st;
    logic [15:0] r_lat [LatDepth];
    logic [AddrW-1:0] r_raddr;
    logic [15:0] r_rdat;
    logic [1:0]  r_rsel;
    logic [15:0] r_v [4];

    logic [31:0] r_x, r_y;
    logic [23:0] r_freq, r_amp;
    logic [LayerW-1:0] r_k;
    logic [3:0]  r_n;
    logic [55:0] r_px, r_py;
    logic [CellW-1:0] r_cx, r_cy;
    logic [15:0] r_fx, r_fy;
    logic [31:0] r_tx, r_ty;
    logic [15:0] r_sx, r_sy;
    logic [33:0] r_top, r_bot;
    logic [15:0] r_oct;
    logic [63:0] r_total;
    logic [27:0] r_asum;
    logic        r_dstart;
    logic        w_ddone;
    logic [15:0] w_q;
    logic [2:0]  r_rdcnt;

    vnf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_total), .i_den(r_asum), .o_done(w_ddone), .o_quot(w_q)
    );

    // lattice memory: one write port (loads), one registered read port
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.op == OpLoad
            && 4'(i_item.layer_index) < 4'(MaxOctaves)
            && 13'(i_item.entry_index) < 13'(TableSize * TableSize))
            r_lat[AddrW'({i_item.layer_index[LayerW-1:0], i_item.entry_index[EntryW-1:0]})]
                <= i_item.entry_value;
        r_rdat <= r_lat[r_raddr];
    end

    logic [CellW-1:0] w_cx1, w_cy1;
    logic [16:0] w_isx, w_isy;
    assign w_cx1 = r_cx + CellW'(1);
    assign w_cy1 = r_cy + CellW'(1);
    assign w_isx = 17'h10000 - 17'(r_sx);
    assign w_isy = 17'h10000 - 17'(r_sy);

    assign o_pop = (r_st == S_IDLE) && !i_empty && !o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; o_valid <= 1'b0; r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (o_pop && i_item.op == OpSample) begin
                    r_x <= i_item.coord_x; r_y <= i_item.coord_y;
                    r_freq <= 24'h010000; r_amp <= 24'h010000;
                    r_k <= '0; r_total <= '0; r_asum <= '0;
                    r_n <= (i_octaves == 4'd0) ? 4'd1 :
                           (i_octaves > 4'(MaxOctaves)) ? 4'(MaxOctaves) : i_octaves;
                    r_st <= S_MULX;
                end
                S_MULX: begin
                    r_px <= 56'($signed(r_x) * $signed({1'b0, r_freq}));
                    r_py <= 56'($signed(r_y) * $signed({1'b0, r_freq}));
                    r_st <= S_SPLT;
                end
                S_SPLT: begin
                    // arithmetic floor is the bits above 32; low bits wrap
                    r_cx <= r_px[32 +: CellW]; r_cy <= r_py[32 +: CellW];
                    r_fx <= r_px[31:16]; r_fy <= r_py[31:16];
                    r_st <= S_SQ;
                end
                S_SQ: begin
                    r_tx <= 32'(r_fx) * 32'(r_fx);
                    r_ty <= 32'(r_fy) * 32'(r_fy);
                    r_raddr <= {r_k, r_cy, r_cx};
                    r_rdcnt <= 3'd0;
                    r_st <= S_SM;
                end
                S_SM: begin
                    r_sx <= 16'((50'(r_tx) * (50'(18'h30000) - 50'({r_fx, 1'b0}))) >> 32);
                    r_sy <= 16'((50'(r_ty) * (50'(18'h30000) - 50'({r_fy, 1'b0}))) >> 32);
                    r_raddr <= {r_k, r_cy, w_cx1};
                    r_rsel <= 2'd0;
                    r_st <= S_RD;
                end
                S_RD: begin
                    // read data is registered and lags the address
                    r_v[r_rsel] <= r_rdat;
                    r_rsel <= r_rsel + 2'd1;
                    r_raddr <= (r_rsel == 2'd0) ? {r_k, w_cy1, r_cx} : {r_k, w_cy1, w_cx1};
                    r_rdcnt <= r_rdcnt + 3'd1;
                    if (r_rdcnt == 3'd3) r_st <= S_ROW;
                end
                S_ROW: begin
                    r_top <= 34'(r_v[0]) * 34'(w_isx) + 34'(r_v[1]) * 34'(r_sx);
                    r_bot <= 34'(r_v[2]) * 34'(w_isx) + 34'(r_v[3]) * 34'(r_sx);
                    r_st <= S_COL;
                end
                S_COL: begin
                    r_oct <= 16'((51'(r_top) * 51'(w_isy) + 51'(r_bot) * 51'(r_sy)) >> 32);
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    r_total <= r_total + 64'(r_oct) * 64'(r_amp);
                    r_asum  <= r_asum + 28'(r_amp);
                    r_freq  <= q824_mul_sat(r_freq, i_lacun);
                    r_amp   <= q824_mul_sat(r_amp, i_gain);
                    r_k     <= r_k + LayerW'(1);
                    if (4'(r_k) + 4'd1 >= r_n) begin
                        r_dstart <= 1'b1;
                        r_st <= S_DIV;
                    end else r_st <= S_MULX;
                end
                S_DIV: if (w_ddone) begin
                    o_value <= w_q;
                    o_valid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/value_noise_fbm_sampler_top.sv
// value_noise_fbm_sampler_top: fractal value noise sampler, load and sample items
// loads are queued, then written to the lattice when the back end pops them
// the back end takes one item at a time and pops no new item while busy; queue holds 4
// the bit-serial divider and the octave sequence set the sample time
// reset: synchronous active-low, registers return to 4 octaves, 2.0, 0.5
// the lattice memory is not cleared; every entry must be loaded before use, the block does not enforce it

module value_noise_fbm_sampler_top
    import vnf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata lsb up: coord_x, coord_y, layer_index, entry_index, entry_value
    input  logic [95:0] s_axis_tdata,
    // tuser: operation
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: noise_value
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    logic [3:0]  r_octaves;
    logic [23:0] r_lacun, r_gain;
    t_item       w_in, w_qitem;
    logic        w_full, w_empty, w_pop;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octaves <= 4'd4; r_lacun <= 24'd131072; r_gain <= 24'd32768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegOctaves: r_octaves <= i_cfg_data[3:0];
                RegLacun:   r_lacun   <= i_cfg_data;
                RegGain:    r_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: unpack and queue items
    assign w_in.op          = s_axis_tuser;
    assign w_in.coord_x     = s_axis_tdata[31:0];
    assign w_in.coord_y     = s_axis_tdata[63:32];
    assign w_in.layer_index = s_axis_tdata[66:64];
    assign w_in.entry_index = s_axis_tdata[78:67];
    assign w_in.entry_value = s_axis_tdata[94:79];
    assign s_axis_tready    = !w_full;

    vnf_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid), .i_item(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_item(w_qitem)
    );

    // back: octave walk and normalize
    vnf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(w_empty), .i_item(w_qitem), .o_pop(w_pop),
        .i_octaves(r_octaves), .i_lacun(r_lacun), .i_gain(r_gain),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_value(m_axis_tdata)
    );

    // a result never appears while the queue is being popped
    a_no_pop_while_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !w_pop) else $error("pop while result pending");
    // a stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for value_noise_fbm_sampler_top
// depends on vnf_pkg and the sampler rtl; holds its own fixed-point noise predictor
`timescale 1ns / 1ps

module tb_top;
    import vnf_pkg::*;

    // index with no register behind it, writes must be dropped
    localparam logic [1:0] RegNone = 2'd3;
    localparam int LayerSize  = TableSize * TableSize;
    localparam int IdleWait   = 200;    // covers the worst sample at eight octaves
    localparam int StallLimit = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    value_noise_fbm_sampler_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state: lattice copy, loaded marks and register copies
    logic [15:0] lattice_copy [0:LatDepth-1];
    bit          loaded_flag [0:LatDepth-1];
    logic [3:0]  octaves_reg = 4'd4;
    logic [23:0] lacun_reg   = 24'd131072;
    logic [23:0] gain_reg    = 24'd32768;

    logic [15:0] noise_expected [$];
    int          fail_count = 0;
    int          burst_left = 0;

    // q8.16 multiply, saturated to 24 bits
    function automatic logic [23:0] scale_sat(input logic [23:0] a, input logic [23:0] b);
        logic [63:0] p;
        p = (64'(a) * 64'(b)) >> 16;
        return (p > 64'hFFFFFF) ? 24'hFFFFFF : p[23:0];
    endfunction

    // q0.16 smoothstep weight
    function automatic logic [63:0] smooth_q16(input logic [15:0] t);
        logic [63:0] tt;
        tt = 64'(t) * 64'(t);
        return (tt * (64'd196608 - 64'd2 * 64'(t))) >> 32;
    endfunction

    // octave count after the zero and max clamps
    function automatic int octaves_used();
        int n;
        n = int'(octaves_reg);
        if (n == 0) n = 1;
        if (n > MaxOctaves) n = MaxOctaves;
        return n;
    endfunction

    // lattice address of one corner (0 top-left .. 3 bottom-right) in octave k
    function automatic int corner_addr(input int k, input logic [31:0] cx,
                                       input logic [31:0] cy, input logic [23:0] freq,
                                       input int corner);
        logic signed [63:0] px, py;
        logic [5:0]  x0, y0;
        px = $signed(cx) * $signed({1'b0, freq});
        py = $signed(cy) * $signed({1'b0, freq});
        x0 = 6'(px >>> 32) + 6'(corner % 2);
        y0 = 6'(py >>> 32) + 6'(corner / 2);
        return k * LayerSize + int'(y0) * TableSize + int'(x0);
    endfunction

    // number of lattice reads of a sample that hit entries never loaded
    function automatic int count_unloaded(input logic [31:0] cx, input logic [31:0] cy);
        int          cnt;
        logic [23:0] freq;
        cnt = 0;
        freq = 24'd65536;
        for (int k = 0; k < octaves_used(); k++) begin
            for (int c = 0; c < 4; c++)
                if (!loaded_flag[corner_addr(k, cx, cy, freq, c)]) cnt++;
            freq = scale_sat(freq, lacun_reg);
        end
        return cnt;
    endfunction

    // fractal noise for one sample at the current register settings
    function automatic logic [15:0] noise_predict(input logic [31:0] cx, input logic [31:0] cy);
        int          n;
        logic [23:0] freq, amp;
        logic [63:0] total, amp_sum, q, sx, sy, top, bot, v00, v10, v01, v11;
        logic signed [63:0] px, py;
        logic [5:0]  x0, y0, x1, y1;
        int          base;
        n = octaves_used();
        freq = 24'd65536;
        amp = 24'd65536;
        total = 0;
        amp_sum = 0;
        for (int k = 0; k < n; k++) begin
            px = $signed(cx) * $signed({1'b0, freq});
            py = $signed(cy) * $signed({1'b0, freq});
            // arithmetic shift is the floor; low bits are the residue mod 64
            x0 = 6'(px >>> 32);
            y0 = 6'(py >>> 32);
            x1 = x0 + 6'd1;
            y1 = y0 + 6'd1;
            sx = smooth_q16(px[31:16]);
            sy = smooth_q16(py[31:16]);
            base = k * LayerSize;
            v00 = 64'(lattice_copy[base + y0 * TableSize + x0]);
            v10 = 64'(lattice_copy[base + y0 * TableSize + x1]);
            v01 = 64'(lattice_copy[base + y1 * TableSize + x0]);
            v11 = 64'(lattice_copy[base + y1 * TableSize + x1]);
            top = v00 * (64'd65536 - sx) + v10 * sx;
            bot = v01 * (64'd65536 - sx) + v11 * sx;
            total += ((top * (64'd65536 - sy) + bot * sy) >> 32) * 64'(amp);
            amp_sum += 64'(amp);
            freq = scale_sat(freq, lacun_reg);
            amp = scale_sat(amp, gain_reg);
        end
        q = total / amp_sum;
        return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    endfunction

    // one item out, bursts with random gaps; predictor updated on acceptance
    task automatic send_item(input logic op, input logic [31:0] cx, input logic [31:0] cy,
                             input logic [2:0] layer, input logic [11:0] entry,
                             input logic [15:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, value, entry, layer, cy, cx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OpLoad) begin
            lattice_copy[int'(layer) * LayerSize + int'(entry)] = value;
            loaded_flag[int'(layer) * LayerSize + int'(entry)] = 1'b1;
        end else
            noise_expected.push_back(noise_predict(cx, cy));
    endtask

    task automatic load(input logic [2:0] layer, input logic [11:0] entry,
                        input logic [15:0] value);
        send_item(OpLoad, $urandom, $urandom, layer, entry, value);
    endtask

    // load any lattice entry that the sample would read before it is written
    task automatic cover_reads(input logic [31:0] cx, input logic [31:0] cy);
        logic [23:0] freq;
        int          a;
        freq = 24'd65536;
        for (int k = 0; k < octaves_used(); k++) begin
            for (int c = 0; c < 4; c++) begin
                a = corner_addr(k, cx, cy, freq, c);
                if (!loaded_flag[a])
                    load(3'(a / LayerSize), 12'(a % LayerSize), 16'($urandom));
            end
            freq = scale_sat(freq, lacun_reg);
        end
    endtask

    task automatic sample(input logic [31:0] cx, input logic [31:0] cy);
        cover_reads(cx, cy);
        send_item(OpSample, cx, cy, 3'($urandom), 12'($urandom), 16'($urandom));
    endtask

    // stop the stream, drain all results, then let a trailing sample finish
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (noise_expected.size() != 0) @(posedge i_clk);
        repeat (IdleWait) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            RegOctaves: octaves_reg = data[3:0];
            RegLacun:   lacun_reg = data;
            RegGain:    gain_reg = data;
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [23:0] oct, input logic [23:0] lac,
                            input logic [23:0] gn);
        drain();
        write_reg(RegOctaves, oct);
        write_reg(RegLacun, lac);
        write_reg(RegGain, gn);
    endtask

    // one of the window cells 62, 63, 0, 1 around the wrap point
    function automatic logic [5:0] win_cell();
        return 6'd62 + 6'($urandom_range(0, 3));
    endfunction

    // every layer gets the 4x4 window around the origin, which spans the wrap
    task automatic test_fill_lattice;
        for (int l = 0; l < MaxOctaves; l++)
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    load(3'(l), {6'd62 + 6'(r), 6'd62 + 6'(c)},
                         (r == 2 && c == 2) ? 16'h0000 :
                         (r == 2 && c == 3) ? 16'hFFFF : 16'($urandom));
    endtask

    // corner coordinates and register extremes
    task automatic test_directed;
        sample(32'h0, 32'h0);
        sample(32'h7FFFFFFF, 32'h7FFFFFFF);
        sample(32'h80000000, 32'h80000000);
        sample(32'hFFFFF000, 32'h00001800);     // negative fraction, floor rounds down
        sample(32'hFFFFFFFF, 32'h00001FFF);
        sample(32'h00001000, 32'hFFFFE000);
        // zero octave count acts as one, above max clamps to max
        set_regs(24'd0, 24'd131072, 24'd32768);
        sample(32'h003F3456, 32'hFFC0CBA9);
        set_regs(24'hFFFFFF, 24'd131072, 24'd32768);   // upper data bits dropped
        sample(32'h00000156, 32'hFFFFFEA9);
        // zero lacunarity and gain collapse the later octaves
        set_regs(24'd8, 24'd0, 24'd0);
        sample(32'h7FC05678, 32'h80001EF0);
        // saturating frequency and amplitude
        set_regs(24'd8, 24'hFFFFFF, 24'hFFFFFF);
        sample(32'h7FFFFFFF, 32'h80000000);
        sample(32'h00000001, 32'hFFFFFFFF);
        set_regs(24'd1, 24'd65536, 24'd65536);
        sample(32'h00008000, 32'h00008000);
        // writes to the unused index must leave the registers alone
        drain();
        write_reg(RegNone, 24'hFFFFFF);
        sample(32'h003F4321, 32'h00002345);
    endtask

    function automatic logic [31:0] rand_coord;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);  // +-16 units
            2: return {16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0), 16'($urandom)};
            default: return 32'($urandom) & 32'h807FFFFF;
        endcase
    endfunction

    // random point, pulled toward the origin until every read hits a loaded entry
    task automatic sample_random;
        logic [31:0] cx, cy;
        cx = rand_coord();
        cy = rand_coord();
        for (int t = 0; t < 32 && count_unloaded(cx, cy) != 0; t++) begin
            cx = 32'($signed(cx) >>> 1);
            cy = 32'($signed(cy) >>> 1);
        end
        sample(cx, cy);
    endtask

    // random register settings per phase, mostly samples with some reloads
    task automatic test_random;
        logic [23:0] oct, lac, gn;
        for (int ph = 0; ph < 9; ph++) begin
            oct = ($urandom_range(0, 5) == 0) ? 24'($urandom_range(0, 15))
                                               : 24'($urandom_range(1, 8));
            if ($urandom_range(0, 3) == 0) oct[23:4] = 20'($urandom);
            case ($urandom_range(0, 3))
                0: lac = 24'($urandom);
                1: lac = 24'($urandom_range(65536, 262144));
                2: lac = ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0);
                default: lac = 24'($urandom_range(0, 131072));
            endcase
            gn = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'($urandom_range(0, 98304));
            set_regs(oct, lac, gn);
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 5) == 0)
                    load(3'($urandom), {win_cell(), win_cell()}, 16'($urandom));
                else
                    sample_random();
            end
        end
    endtask

    // result checker with its own stall pattern: free-run, random, long stalls
    int rx_mode = 0;
    int rx_count = 0;
    int rx_hold = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (noise_expected.size() == 0) begin
                $display("%0t: unexpected noise result %h", $time, m_axis_tdata);
                fail_count++;
            end else begin
                if (m_axis_tdata !== noise_expected[0]) begin
                    $display("%0t: noise_value expected %h actual %h",
                             $time, noise_expected[0], m_axis_tdata);
                    fail_count++;
                end
                void'(noise_expected.pop_front());
            end
        end
        rx_count++;
        if (rx_count == 300) begin
            rx_count = 0;
            rx_mode = $urandom_range(0, 2);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_mode == 1) begin
            m_axis_tready <= ($urandom_range(0, 9) < 7);
        end else if (rx_mode == 2 && $urandom_range(0, 15) == 0) begin
            rx_hold = $urandom_range(1, 20);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake anywhere
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_lattice();
        test_directed();
        test_random();
        drain();
        if (fail_count == 0 && noise_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
